FILE: rtl/tkpsa_pkg.sv
// Shared types and constants for the top-k priority slot allocator.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package tkpsa_pkg;

  localparam int MODE_W  = 2;
  localparam int PID_W   = 6;
  localparam int PRIO_W  = 16;
  localparam int FRAME_W = 32;
  localparam int SLOT_W  = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_REQ   = 2'd0,
    MODE_QUERY = 2'd1,
    MODE_UNREG = 2'd2,
    MODE_MARK  = 2'd3
  } mode_t;

  // Updates that the controller applies to the pending table.
  typedef enum logic [2:0] {
    PEND_NOP     = 3'd0,
    PEND_REQ     = 3'd1,
    PEND_REQ_CLR = 3'd2,
    PEND_UNREG   = 3'd3,
    PEND_MARK    = 3'd4
  } pend_op_t;

endpackage

`default_nettype wire

FILE: rtl/tkpsa_if.sv
// Handshake interfaces for the request and result words of the allocator.
// Depends on tkpsa_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface tkpsa_in_if;
  import tkpsa_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic [PID_W-1:0]         portal_id;
  logic signed [PRIO_W-1:0] priority_req;
  logic [FRAME_W-1:0]       frame_id;

  modport source (output valid, mode, portal_id, priority_req, frame_id, input ready);
  modport sink   (input valid, mode, portal_id, priority_req, frame_id, output ready);
endinterface

interface tkpsa_out_if;
  import tkpsa_pkg::*;

  logic              valid;
  logic              ready;
  logic              hot;
  logic [SLOT_W-1:0] slot;
  logic              was_hot;

  modport source (output valid, hot, slot, was_hot, input ready);
  modport sink   (input valid, hot, slot, was_hot, output ready);
endinterface

`default_nettype wire

FILE: rtl/top_k_priority_slot_allocator.sv
// Top level of the top-k priority slot allocator.
// Depends on tkpsa_pkg, tkpsa_if, tkpsa_pend and tkpsa_cell.
//
// Usage: each word on in_ch carries a mode, a client id, a signed Q8.8
// priority and a frame number. Every accepted word yields exactly one word
// on out_ch: hot and slot tell whether and where the client owns a slot
// now, was_hot whether it owned one in the previous frame.
// Queries, unregisters, marks and requests within the same frame are answered
// directly: the result word is valid on the cycle after acceptance.
// A request from an in-range client with a new frame number reallocates the
// pool. The pending table is swept one entry per cycle through its memory
// read port into a chain of POOL_SIZE sorting cells; the sequencer steps
// through its scan, drain and done states before the result word is loaded,
// and no other word is accepted until then.
// The output is a register; a new word is accepted while a result waits as
// long as the receiver takes that result in the same cycle. While the
// receiver stalls, the result holds and in_ch.ready stays low.
// Reset (rst_n low at a clock edge) empties all slots, the pending and dying
// flags and the output register, and sets the stored frame number to zero.
// The priority memory is not cleared; an entry is only used once written.
`timescale 1ns / 1ps
`default_nettype none

module top_k_priority_slot_allocator
  import tkpsa_pkg::*;
#(
  parameter int POOL_SIZE   = 4,
  parameter int MAX_CLIENTS = 64
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  tkpsa_in_if.sink    in_ch,
  tkpsa_out_if.source out_ch
);

  localparam int IDX_W = $clog2(MAX_CLIENTS);
  localparam int PW    = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(MAX_CLIENTS - 1);
  localparam logic [PW-1:0]    LAST_CELL = PW'(POOL_SIZE - 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state_r;
  logic [IDX_W-1:0] scan_r;
  logic [PW-1:0]    drain_r;

  // Slot owner tables.
  logic [POOL_SIZE-1:0] cur_vld_r;
  logic [IDX_W-1:0]     cur_id_r [POOL_SIZE];
  logic [POOL_SIZE-1:0] prev_vld_r;
  logic [IDX_W-1:0]     prev_id_r [POOL_SIZE];
  logic [FRAME_W-1:0]   last_frame_r;

  // The request that triggered a reallocation, held until it completes.
  logic [IDX_W-1:0]         itm_id_r;
  logic signed [PRIO_W-1:0] itm_prio_r;
  logic [FRAME_W-1:0]       itm_frame_r;

  logic              out_vld_r;
  logic              out_hot_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic              out_was_r;

  logic       in_acc;
  logic       in_range;
  logic       realloc;
  logic       out_load;
  mode_t      in_mode;
  logic [IDX_W-1:0] in_idx;

  logic [POOL_SIZE-1:0] cur_upd_vld;
  logic [POOL_SIZE-1:0] prev_upd_vld;

  // Pending table interface.
  pend_op_t                 pend_op;
  logic [IDX_W-1:0]         pend_idx;
  logic signed [PRIO_W-1:0] pend_prio;
  logic                     rd_elig;
  logic [IDX_W-1:0]         rd_id;
  logic signed [PRIO_W-1:0] rd_prio;

  // Sorting chain: element k feeds cell k, element POOL_SIZE leaves the chain.
  logic                     chain_vld  [POOL_SIZE+1];
  logic [IDX_W-1:0]         chain_id   [POOL_SIZE+1];
  logic signed [PRIO_W-1:0] chain_prio [POOL_SIZE+1];
  logic [POOL_SIZE-1:0]     cell_vld;
  logic [IDX_W-1:0]         cell_id [POOL_SIZE];

  // Result lookup.
  logic [POOL_SIZE-1:0] res_cur_vld;
  logic [POOL_SIZE-1:0] res_prev_vld;
  logic [IDX_W-1:0]     res_id;
  logic                 res_range;
  logic                 res_hot;
  logic [SLOT_W-1:0]    res_slot;
  logic                 res_was;

  assign in_mode  = mode_t'(in_ch.mode);
  assign in_idx   = IDX_W'(in_ch.portal_id);
  assign in_range = 32'(in_ch.portal_id) < 32'(MAX_CLIENTS);
  assign realloc  = in_range && (in_mode == MODE_REQ) && (in_ch.frame_id != last_frame_r);

  // A new word enters only while idle and when the output register is free
  // or being emptied in this cycle.
  assign in_ch.ready = (state_r == ST_IDLE) && (!out_vld_r || out_ch.ready);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_load    = (in_acc && !realloc) || (state_r == ST_DONE);

  // Unregister drops the client from both owner tables.
  always_comb begin
    cur_upd_vld  = cur_vld_r;
    prev_upd_vld = prev_vld_r;
    if (in_range && in_mode == MODE_UNREG) begin
      for (int k = 0; k < POOL_SIZE; k++) begin
        if (cur_id_r[k] == in_idx) begin
          cur_upd_vld[k] = 1'b0;
        end
        if (prev_id_r[k] == in_idx) begin
          prev_upd_vld[k] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    pend_op   = PEND_NOP;
    pend_idx  = in_idx;
    pend_prio = in_ch.priority_req;
    if (state_r == ST_DONE) begin
      pend_op   = PEND_REQ_CLR;
      pend_idx  = itm_id_r;
      pend_prio = itm_prio_r;
    end else if (in_acc && in_range && !realloc) begin
      case (in_mode)
        MODE_REQ:   pend_op = PEND_REQ;
        MODE_UNREG: pend_op = PEND_UNREG;
        MODE_MARK:  pend_op = PEND_MARK;
        default:    pend_op = PEND_NOP;
      endcase
    end
  end

  tkpsa_pend #(
    .DEPTH (MAX_CLIENTS),
    .IDX_W (IDX_W)
  ) u_pend (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_op    (pend_op),
    .cmd_idx   (pend_idx),
    .cmd_prio  (pend_prio),
    .rd_en     (state_r == ST_SCAN),
    .rd_idx    (scan_r),
    .rd_elig_r (rd_elig),
    .rd_id_r   (rd_id),
    .rd_prio_r (rd_prio)
  );

  assign chain_vld[0]  = rd_elig;
  assign chain_id[0]   = rd_id;
  assign chain_prio[0] = rd_prio;

  // Each cell keeps the best candidate it has seen and hands the loser to
  // its neighbor, so after the sweep cell k holds the k-th best client.
  for (genvar g = 0; g < POOL_SIZE; g++) begin : g_cell
    tkpsa_cell #(
      .IDX_W (IDX_W)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .clr         (in_acc && realloc),
      .in_vld      (chain_vld[g]),
      .in_id       (chain_id[g]),
      .in_prio     (chain_prio[g]),
      .pass_vld_r  (chain_vld[g+1]),
      .pass_id_r   (chain_id[g+1]),
      .pass_prio_r (chain_prio[g+1]),
      .hold_vld_r  (cell_vld[g]),
      .hold_id_r   (cell_id[g])
    );
  end

  // Sequencer: sweep every pending entry, then let the last candidate ripple
  // through the chain, then commit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      scan_r  <= '0;
      drain_r <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          scan_r  <= '0;
          drain_r <= '0;
          if (in_acc && realloc) begin
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          scan_r <= scan_r + 1'b1;
          if (scan_r == LAST_IDX) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          drain_r <= drain_r + 1'b1;
          if (drain_r == LAST_CELL) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r    <= '0;
      prev_vld_r   <= '0;
      last_frame_r <= '0;
    end else if (state_r == ST_DONE) begin
      cur_vld_r    <= cell_vld;
      last_frame_r <= itm_frame_r;
    end else if (in_acc && realloc) begin
      prev_vld_r <= cur_vld_r;
    end else if (in_acc) begin
      cur_vld_r  <= cur_upd_vld;
      prev_vld_r <= prev_upd_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE) begin
      cur_id_r <= cell_id;
    end else if (in_acc && realloc) begin
      prev_id_r   <= cur_id_r;
      itm_id_r    <= in_idx;
      itm_prio_r  <= in_ch.priority_req;
      itm_frame_r <= in_ch.frame_id;
    end
  end

  // Result lookup against the owner tables as they stand after the word.
  always_comb begin
    if (state_r == ST_DONE) begin
      res_cur_vld  = cell_vld;
      res_prev_vld = prev_vld_r;
      res_id       = itm_id_r;
      res_range    = 1'b1;
    end else begin
      res_cur_vld  = cur_upd_vld;
      res_prev_vld = prev_upd_vld;
      res_id       = in_idx;
      res_range    = in_range;
    end
    res_hot  = 1'b0;
    res_slot = '0;
    res_was  = 1'b0;
    // Walk down so that the lowest matching slot wins.
    for (int k = POOL_SIZE - 1; k >= 0; k--) begin
      if (res_cur_vld[k] &&
          (((state_r == ST_DONE) ? cell_id[k] : cur_id_r[k]) == res_id)) begin
        res_hot  = 1'b1;
        res_slot = SLOT_W'(k);
      end
      if (res_prev_vld[k] && (prev_id_r[k] == res_id)) begin
        res_was = 1'b1;
      end
    end
    if (!res_range) begin
      res_hot  = 1'b0;
      res_slot = '0;
      res_was  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_hot_r  <= res_hot;
      out_slot_r <= res_slot;
      out_was_r  <= res_was;
    end
  end

  assign out_ch.valid   = out_vld_r;
  assign out_ch.hot     = out_hot_r;
  assign out_ch.slot    = out_slot_r;
  assign out_ch.was_hot = out_was_r;

endmodule

`default_nettype wire

FILE: rtl/tkpsa_pend.sv
// Pending table: priority memory with a registered read port, plus the
// pending and dying flags per client. Depends on tkpsa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tkpsa_pend
  import tkpsa_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int IDX_W = 6
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire pend_op_t                 cmd_op,
  input  wire logic [IDX_W-1:0]         cmd_idx,
  input  wire logic signed [PRIO_W-1:0] cmd_prio,
  input  wire logic                     rd_en,
  input  wire logic [IDX_W-1:0]         rd_idx,
  output logic                          rd_elig_r,
  output logic [IDX_W-1:0]              rd_id_r,
  output logic signed [PRIO_W-1:0]      rd_prio_r
);

  logic signed [PRIO_W-1:0] prio_mem [DEPTH];
  logic [DEPTH-1:0]         pend_vld_r;
  logic [DEPTH-1:0]         dying_r;

  // Priority memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd_op == PEND_REQ || cmd_op == PEND_REQ_CLR) begin
      prio_mem[cmd_idx] <= cmd_prio;
    end
    if (rd_en) begin
      rd_prio_r <= prio_mem[rd_idx];
    end
    rd_id_r <= rd_idx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= '0;
      dying_r    <= '0;
      rd_elig_r  <= 1'b0;
    end else begin
      rd_elig_r <= rd_en && pend_vld_r[rd_idx] && !dying_r[rd_idx];
      case (cmd_op)
        PEND_REQ: begin
          pend_vld_r[cmd_idx] <= 1'b1;
        end
        PEND_REQ_CLR: begin
          // A new frame empties the table before this request is recorded.
          pend_vld_r <= DEPTH'(1) << cmd_idx;
        end
        PEND_UNREG: begin
          pend_vld_r[cmd_idx] <= 1'b0;
          dying_r[cmd_idx]    <= 1'b0;
        end
        PEND_MARK: begin
          dying_r[cmd_idx] <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tkpsa_cell.sv
// One cell of the insertion-sort chain that ranks candidates by priority.
// Depends on tkpsa_pkg for the priority width.
`timescale 1ns / 1ps
`default_nettype none

module tkpsa_cell
  import tkpsa_pkg::*;
#(
  parameter int IDX_W = 6
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     clr,
  input  wire logic                     in_vld,
  input  wire logic [IDX_W-1:0]         in_id,
  input  wire logic signed [PRIO_W-1:0] in_prio,
  output logic                          pass_vld_r,
  output logic [IDX_W-1:0]              pass_id_r,
  output logic signed [PRIO_W-1:0]      pass_prio_r,
  output logic                          hold_vld_r,
  output logic [IDX_W-1:0]              hold_id_r
);

  logic signed [PRIO_W-1:0] hold_prio_r;
  logic                     beats;

  // Higher priority wins; on a tie the lower id wins.
  assign beats = in_vld && (!hold_vld_r || (in_prio > hold_prio_r) ||
                            ((in_prio == hold_prio_r) && (in_id < hold_id_r)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
      pass_vld_r <= 1'b0;
    end else if (clr) begin
      hold_vld_r <= 1'b0;
      pass_vld_r <= 1'b0;
    end else begin
      pass_vld_r <= beats ? hold_vld_r : in_vld;
      if (beats) begin
        hold_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    pass_id_r   <= beats ? hold_id_r : in_id;
    pass_prio_r <= beats ? hold_prio_r : in_prio;
    if (beats) begin
      hold_id_r   <= in_id;
      hold_prio_r <= in_prio;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tkpsa_chk.sv
// Port-level checker for the top-k priority slot allocator and its bind.
// Depends on tkpsa_pkg and top_k_priority_slot_allocator.
`timescale 1ns / 1ps
`default_nettype none

module tkpsa_chk
  import tkpsa_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic [MODE_W-1:0] in_mode,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic              out_hot,
  input wire logic [SLOT_W-1:0] out_slot,
  input wire logic              out_was_hot
);

  // A result word stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // A new word is taken only when the output register can take its result.
  a_in_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (!out_valid || out_ready))
    else $error("input accepted with a stalled result pending");

  // A client without a slot reports slot zero.
  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hot |-> (out_slot == '0))
    else $error("slot nonzero while not hot");

  // An unregister answers in the next cycle, with no slot now or before.
  a_unreg: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_mode == MODE_UNREG) |=>
      out_valid && !out_hot && !out_was_hot)
    else $error("unregister answer wrong or late");

endmodule

bind top_k_priority_slot_allocator tkpsa_chk u_tkpsa_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_mode     (in_ch.mode),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_hot     (out_ch.hot),
  .out_slot    (out_ch.slot),
  .out_was_hot (out_ch.was_hot)
);

`default_nettype wire
